// ===== src/fis_pkg.sv =====
package fis_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_EST   = 2'd1;
   localparam logic [1:0] CMD_LIST  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   // Saturating unsigned add of two Q24.8 weights.
   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // Entry a orders before entry b: smaller weight, then smaller stamp.
   function automatic logic order_before(input logic [31:0] wa, input logic [31:0] sa,
                                         input logic [31:0] wb, input logic [31:0] sb);
      if (wa != wb) begin
         return wa < wb;
      end
      return sa < sb;
   endfunction

endpackage

// ===== src/fis_scan.sv =====
module fis_scan
   import fis_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             step,
   input  logic             cur_valid,
   input  logic [31:0]      cur_key,
   input  logic [31:0]      cur_weight,
   input  logic [31:0]      cur_stamp,
   input  logic [31:0]      match_key,
   input  logic [31:0]      thr,
   input  logic             use_thr,
   input  logic [TABLE_DEPTH-1:0] used,
   input  logic [IDX_W-1:0] idx,
   output logic             hit_ff,
   output logic [IDX_W-1:0] hit_idx_ff,
   output logic             pick_ok_ff,
   output logic [IDX_W-1:0] pick_idx_ff,
   output logic [31:0]      pick_w_ff,
   output logic [31:0]      pick_k_ff,
   output logic             free_ok_ff,
   output logic [IDX_W-1:0] free_idx_ff,
   output logic [CNT_W-1:0] count_ff
);

   logic        qual;
   logic        cand;
   logic [31:0] pick_s_ff;

   // An entry qualifies when it is valid, not yet listed and, in a listing, above the threshold.
   assign qual = cur_valid && !used[idx] && (!use_thr || cur_weight > thr);

   // Shared compare unit: one entry per step against the running minimum.
   assign cand = qual &&
                 (!pick_ok_ff || order_before(cur_weight, cur_stamp, pick_w_ff, pick_s_ff));

   always_ff @(posedge clock) begin
      if (reset || start) begin
         hit_ff     <= 1'b0;
         pick_ok_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         count_ff   <= '0;
      end else if (step) begin
         if (cur_valid && cur_key == match_key && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx;
         end
         // The count covers the qualifying entries, so a listing knows what remains.
         if (cur_valid) begin
            if (qual) begin
               count_ff <= count_ff + 1'b1;
            end
         end else if (!free_ok_ff) begin
            free_ok_ff  <= 1'b1;
            free_idx_ff <= idx;
         end
         if (cand) begin
            pick_ok_ff  <= 1'b1;
            pick_idx_ff <= idx;
            pick_w_ff   <= cur_weight;
            pick_s_ff   <= cur_stamp;
            pick_k_ff   <= cur_key;
         end
      end
   end

endmodule

// ===== src/frequent_items_sketch.sv =====
// Space-saving heavy-hitter sketch over a 16-entry table. Every command except
// clear runs a scan that visits one table entry per cycle through a single
// compare unit. An add scans the whole table and is then written in ST_ACT, after
// which the block is idle for the next item. An estimate presents its result from
// ST_EMIT after the scan, and the next item is accepted once that result is taken.
// A heavy-hitter listing rescans the table for each listed entry, and each result
// waits in ST_OUT while an earlier result is held by rsp_stall; an empty list
// answers from ST_EMIT. The clear command goes through ST_ACT without a scan.
// req_stall is high while a command is in work or a result waits; csr_ready is
// high only while idle.
module frequent_items_sketch
   import fis_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_item_key,
   input  logic [31:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_key,
   output logic [31:0] rsp_out_weight,
   output logic        rsp_found,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_capacity_in_use
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_ACT  = 5'b00100,
      ST_OUT  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [4:0]           cap_ff;
   logic [1:0]           cmd_ff;
   logic [31:0]          key_ff, amt_ff;
   logic [TABLE_DEPTH-1:0] valid_ff, used_ff;
   logic [31:0]          floor_ff, wcnt_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [31:0]          ek [TABLE_DEPTH];
   logic [31:0]          ew [TABLE_DEPTH];
   logic [31:0]          es [TABLE_DEPTH];

   logic                 start, step, scan_end;
   logic                 hit, pick_ok, free_ok;
   logic [IDX_W-1:0]     hit_idx, pick_idx, free_idx;
   logic [31:0]          pick_w, pick_k;
   logic [CNT_W-1:0]     count;
   logic [CNT_W-1:0]     cap_eff;
   logic [31:0]          new_w;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;
   logic [31:0]          wr_w;
   logic                 final_pick;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid;
   assign csr_ready = (state_ff == ST_IDLE) && !rsp_valid;
   assign start     = req_valid && !req_stall;
   assign step      = (state_ff == ST_SCAN);
   assign scan_end  = step && (idx_ff == IDX_W'(TABLE_DEPTH - 1));

   // The listed entry is the final one when no other qualifying entry remains.
   assign final_pick = (count == CNT_W'(1));

   fis_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (start || (state_ff == ST_OUT && !rsp_valid) || state_ff == ST_EMIT),
      .step        (step),
      .cur_valid   (valid_ff[idx_ff]),
      .cur_key     (ek[idx_ff]),
      .cur_weight  (ew[idx_ff]),
      .cur_stamp   (es[idx_ff]),
      .match_key   (key_ff),
      .thr         (amt_ff),
      .use_thr     (cmd_ff == CMD_LIST),
      .used        (used_ff),
      .idx         (idx_ff),
      .hit_ff      (hit),
      .hit_idx_ff  (hit_idx),
      .pick_ok_ff  (pick_ok),
      .pick_idx_ff (pick_idx),
      .pick_w_ff   (pick_w),
      .pick_k_ff   (pick_k),
      .free_ok_ff  (free_ok),
      .free_idx_ff (free_idx),
      .count_ff    (count)
   );

   // Effective capacity clamped to 1..TABLE_DEPTH.
   always_comb begin
      if (cap_ff == 5'd0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap_ff) > TABLE_DEPTH) begin
         cap_eff = CNT_W'(TABLE_DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   // Add decision after the scan.
   always_comb begin
      new_w  = sat_add(amt_ff, floor_ff);
      wr_en  = 1'b0;
      wr_idx = hit_idx;
      wr_w   = sat_add(ew[hit_idx], amt_ff);
      if (hit) begin
         wr_en = 1'b1;
      end else if (count < cap_eff && free_ok) begin
         wr_en  = 1'b1;
         wr_idx = free_idx;
         wr_w   = new_w;
      end else if (pick_ok && new_w > pick_w) begin
         wr_en  = 1'b1;
         wr_idx = pick_idx;
         wr_w   = new_w;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = (req_cmd == CMD_CLEAR) ? ST_ACT : ST_SCAN;
         ST_SCAN: if (scan_end) state_in = ST_ACT;
         ST_ACT: begin
            if (cmd_ff == CMD_LIST) begin
               state_in = pick_ok ? ST_OUT : ST_EMIT;
            end else if (cmd_ff == CMD_EST) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT:  if (!rsp_valid) state_in = final_pick ? ST_IDLE : ST_SCAN;
         ST_EMIT: if (!rsp_valid) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff   <= 5'd16;
         valid_ff <= '0;
         floor_ff <= '0;
         wcnt_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity_in_use;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         if (start) begin
            cmd_ff  <= req_cmd;
            key_ff  <= req_item_key;
            amt_ff  <= req_amount;
            idx_ff  <= '0;
            used_ff <= '0;
         end
         if (step) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (state_ff == ST_ACT) begin
            case (cmd_ff)
               CMD_ADD: begin
                  if (wr_en) begin
                     ek[wr_idx]       <= key_ff;
                     ew[wr_idx]       <= wr_w;
                     es[wr_idx]       <= wcnt_ff;
                     valid_ff[wr_idx] <= 1'b1;
                     wcnt_ff          <= wcnt_ff + 1'b1;
                  end
                  if (!hit && !(count < cap_eff && free_ok)) begin
                     if (wr_en) begin
                        if (pick_w > floor_ff) floor_ff <= pick_w;
                     end else if (new_w > floor_ff) begin
                        floor_ff <= new_w;
                     end
                  end
               end
               CMD_CLEAR: begin
                  valid_ff <= '0;
                  floor_ff <= '0;
                  wcnt_ff  <= '0;
               end
               default: ;
            endcase
         end
         // A listed entry waits in ST_OUT until the slot frees.
         if (state_ff == ST_OUT && !rsp_valid) begin
            rsp_valid      <= 1'b1;
            rsp_out_key    <= pick_k;
            rsp_out_weight <= pick_w;
            rsp_found      <= 1'b1;
            rsp_last       <= final_pick;
            used_ff[pick_idx] <= 1'b1;
            idx_ff         <= '0;
         end
         // Single item: estimate or empty list.
         if (state_ff == ST_EMIT && !rsp_valid) begin
            rsp_valid <= 1'b1;
            rsp_last  <= 1'b1;
            if (cmd_ff == CMD_EST) begin
               rsp_out_key    <= key_ff;
               rsp_out_weight <= hit ? ew[hit_idx] : floor_ff;
               rsp_found      <= hit;
            end else begin
               rsp_out_key    <= '0;
               rsp_out_weight <= '0;
               rsp_found      <= 1'b0;
            end
         end
      end
   end

endmodule

// ===== bench/frequent_items_sketch_test.sv =====
module frequent_items_sketch_test
   import fis_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT_ITEM = 150;
   localparam int RANDOM_PER_PHASE = 80;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] weight;
      logic        found;
      logic        last;
   } sketch_result_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [31:0]       key;
      logic [31:0]       amount;
      logic              typed;
      sketch_result_type result;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_ADD;
   logic [31:0] req_item_key = '0;
   logic [31:0] req_amount = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_out_key;
   logic [31:0] rsp_out_weight;
   logic        rsp_found;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_capacity_in_use = '0;

   // Shadow copy of the sketch table.
   logic [31:0] shadow_key [TABLE_DEPTH];
   logic [31:0] shadow_weight [TABLE_DEPTH];
   logic [31:0] shadow_stamp [TABLE_DEPTH];
   logic        shadow_valid [TABLE_DEPTH];
   logic [31:0] shadow_floor;
   logic [31:0] shadow_writes;
   logic [4:0]  shadow_capacity;

   sketch_result_type expected_results[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int csr_writes = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   int stall_left = 0;
   int free_left = 0;
   bit hold_done = 1'b0;
   bit calm = 1'b0;

   frequent_items_sketch u_dut (.*);

   always #5 clock = ~clock;

   function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic bit orders_first(int a, int b);
      if (shadow_weight[a] != shadow_weight[b]) begin
         return shadow_weight[a] < shadow_weight[b];
      end
      return shadow_stamp[a] < shadow_stamp[b];
   endfunction

   function automatic int lookup_key(logic [31:0] key);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (shadow_valid[i] && shadow_key[i] == key) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Appends one expected item at the tail of the queue.
   function automatic void queue_result(sketch_result_type r);
      expected_results = {expected_results, r};
   endfunction

   task automatic clear_shadow();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_key[i] = '0;
         shadow_weight[i] = '0;
         shadow_stamp[i] = '0;
      end
      shadow_floor = '0;
      shadow_writes = '0;
   endtask

   task automatic write_slot(int i, logic [31:0] key, logic [31:0] w);
      shadow_key[i] = key;
      shadow_weight[i] = w;
      shadow_stamp[i] = shadow_writes;
      shadow_valid[i] = 1'b1;
      shadow_writes = shadow_writes + 1;
   endtask

   // Space-saving update: bump a tracked key, else insert, evict or raise the floor.
   task automatic sketch_add(logic [31:0] key, logic [31:0] delta);
      int hit, free_slot, smallest, count, cap;
      logic [31:0] w;
      hit = lookup_key(key);
      free_slot = -1;
      smallest = -1;
      count = 0;
      if (hit >= 0) begin
         write_slot(hit, key, add_clamped(shadow_weight[hit], delta));
         return;
      end
      cap = (shadow_capacity == 0) ? 1 : (shadow_capacity > TABLE_DEPTH) ? TABLE_DEPTH
            : shadow_capacity;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (shadow_valid[i]) begin
            count++;
            if (smallest < 0 || orders_first(i, smallest)) begin
               smallest = i;
            end
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      w = add_clamped(delta, shadow_floor);
      if (count < cap && free_slot >= 0) begin
         write_slot(free_slot, key, w);
      end else if (smallest >= 0 && w > shadow_weight[smallest]) begin
         if (shadow_weight[smallest] > shadow_floor) begin
            shadow_floor = shadow_weight[smallest];
         end
         write_slot(smallest, key, w);
      end else if (w > shadow_floor) begin
         shadow_floor = w;
      end
   endtask

   // Works out the results of one command and updates the shadow table.
   task automatic predict_sketch(logic [1:0] cmd, logic [31:0] key, logic [31:0] amount,
                                 bit typed, sketch_result_type typed_result);
      bit picked [TABLE_DEPTH];
      int n, pick, hit;
      sketch_result_type r;
      n = 0;
      case (cmd)
         CMD_ADD: begin
            sketch_add(key, amount);
         end
         CMD_EST: begin
            hit = lookup_key(key);
            r.key = key;
            r.weight = (hit >= 0) ? shadow_weight[hit] : shadow_floor;
            r.found = (hit >= 0);
            r.last = 1'b1;
            queue_result(typed ? typed_result : r);
         end
         CMD_LIST: begin
            if (typed) begin
               queue_result(typed_result);
               return;
            end
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               picked[i] = 1'b0;
            end
            while (n < 16) begin
               pick = -1;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (shadow_valid[i] && !picked[i] && shadow_weight[i] > amount) begin
                     if (pick < 0 || orders_first(i, pick)) begin
                        pick = i;
                     end
                  end
               end
               if (pick < 0) begin
                  break;
               end
               picked[pick] = 1'b1;
               r = '{shadow_key[pick], shadow_weight[pick], 1'b1, 1'b0};
               queue_result(r);
               n++;
            end
            if (n == 0) begin
               r = '{32'd0, 32'd0, 1'b0, 1'b1};
               queue_result(r);
            end else begin
               expected_results[$].last = 1'b1;
            end
         end
         default: begin
            clear_shadow();
         end
      endcase
   endtask

   // Offers one item after a random gap and holds it until accepted.
   task automatic send_item(logic [1:0] cmd, logic [31:0] key, logic [31:0] amount,
                            bit typed, sketch_result_type typed_result);
      int gap;
      gap = 0;
      if (!calm) begin
         gap = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 60)
               : ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_item_key <= key;
      req_amount <= amount;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      predict_sketch(cmd, key, amount, typed, typed_result);
   endtask

   task automatic wait_quiet();
      while (expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Capacity writes happen only with the block idle.
   task automatic write_capacity(logic [4:0] value);
      req_valid <= 1'b0;
      wait_quiet();
      csr_valid <= 1'b1;
      csr_capacity_in_use <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shadow_capacity = value;
      csr_writes++;
   endtask

   // Mostly a small key pool so that hits, ties and evictions are common.
   task automatic random_item();
      logic [1:0] cmd;
      logic [31:0] key, amount;
      int pick, sel;
      pick = $urandom_range(0, 99);
      cmd = (pick < 60) ? CMD_ADD : (pick < 80) ? CMD_EST : (pick < 97) ? CMD_LIST
            : CMD_CLEAR;
      key = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 23);
      case ($urandom_range(0, 9))
         0: amount = $urandom();
         1: amount = 32'hFFFF_FFFF - $urandom_range(0, 3);
         2: amount = '0;
         default: amount = $urandom_range(1, 32'h800);
      endcase
      if (cmd == CMD_LIST && $urandom_range(0, 2) != 0) begin
         sel = $urandom_range(0, TABLE_DEPTH - 1);
         amount = shadow_valid[sel] ? shadow_weight[sel] - $urandom_range(0, 1)
                  : $urandom_range(0, 32'h400);
      end
      send_item(cmd, key, amount, 1'b0, '0);
   endtask

   // Result channel back-pressure with one long hold-off to fill the block.
   always @(posedge clock) begin
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
         hold_done <= 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         if ($urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(20, 80);
         end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 4);
         end else begin
            free_left = $urandom_range(0, 8);
         end
         rsp_stall <= 1'b0;
      end
   end

   // Result checking and the watchdog.
   always @(posedge clock) begin
      sketch_result_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("frequent_items_sketch: mismatch");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("unexpected item: key %h weight %h", rsp_out_key, rsp_out_weight);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_out_key !== want.key) begin
                  $error("out_key: expected %h, got %h", want.key, rsp_out_key);
                  errors++;
               end
               if (rsp_out_weight !== want.weight) begin
                  $error("out_weight: expected %h, got %h", want.weight, rsp_out_weight);
                  errors++;
               end
               if (rsp_found !== want.found) begin
                  $error("found: expected %b, got %b", want.found, rsp_found);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_last);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      stim_row_type directed[$];
      logic [4:0] phase_capacity[$];
      directed = '{
         '{CMD_EST,   32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, 1'b0, 1'b1}},
         '{CMD_LIST,  32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, 1'b0, 1'b1}},
         '{CMD_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
         '{CMD_EST,   32'hFFFF_FFFF, 32'h0,         1'b1,
           '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1}},
         '{CMD_ADD,   32'hFFFF_FFFF, 32'h1,         1'b0, '0},
         '{CMD_EST,   32'hFFFF_FFFF, 32'h0,         1'b1,
           '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1}},
         '{CMD_ADD,   32'h0,         32'h0,         1'b0, '0},
         '{CMD_EST,   32'h0,         32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, 1'b1, 1'b1}},
         '{CMD_LIST,  32'h0,         32'hFFFF_FFFE, 1'b1,
           '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1}},
         '{CMD_LIST,  32'h0,         32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b1}},
         '{CMD_ADD,   32'h10,        32'h300,       1'b0, '0},
         '{CMD_ADD,   32'h11,        32'h200,       1'b0, '0},
         '{CMD_ADD,   32'h12,        32'h200,       1'b0, '0},
         '{CMD_LIST,  32'h0,         32'h0,         1'b0, '0},
         '{CMD_LIST,  32'h0,         32'h1FF,       1'b0, '0},
         '{CMD_CLEAR, 32'h0,         32'h0,         1'b0, '0},
         '{CMD_EST,   32'h10,        32'h0,         1'b1, '{32'h10, 32'h0, 1'b0, 1'b1}},
         '{CMD_LIST,  32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, 1'b0, 1'b1}}
      };
      phase_capacity = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd4, 5'd9};
      shadow_capacity = 5'd16;
      clear_shadow();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset capacity.
      foreach (directed[i]) begin
         send_item(directed[i].cmd, directed[i].key, directed[i].amount,
                   directed[i].typed, directed[i].result);
      end

      // Random part, one phase per capacity; the table is kept across phases
      // so that lowering the capacity finds it over-full.
      foreach (phase_capacity[p]) begin
         write_capacity(phase_capacity[p]);
         calm = (p == 2);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            random_item();
         end
         calm = 1'b0;
      end
      req_valid <= 1'b0;
      wait_quiet();

      $display("Covered %0d items and %0d results over %0d capacity writes,",
               items_sent, results_seen, csr_writes);
      $display("including saturation, evictions, over-full tables and a long hold-off.");
      if (errors == 0 && expected_results.size() == 0) begin
         $display("frequent_items_sketch: match");
      end else begin
         $display("frequent_items_sketch: mismatch");
      end
      $finish;
   end

endmodule
